// ===== sv/rbb_pkg.sv =====
// Package: shared constants, types and the divide-by-nine helper of the RGB box blur.
package rbb_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int FRAME_WIDTH_W  = 11;
	localparam int FRAME_HEIGHT_W = 13;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_IDX_W      = 1;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int MIN_DIM      = 3;

	localparam int CH_W  = 8;
	localparam int PIX_W = 3 * CH_W;
	localparam int SUM_W = 12;
	localparam int WIN_N = 9;

	localparam int DIV9_MUL   = 7282;
	localparam int DIV9_MUL_W = 13;
	localparam int DIV9_SHIFT = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic emit;
		logic interior;
		logic last;
	} rbb_ctl_t;

	// exact floor(s / 9) for s <= 2295
	function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
		logic [SUM_W+DIV9_MUL_W-1:0] p;
		p = {{DIV9_MUL_W{1'b0}}, s} * (SUM_W+DIV9_MUL_W)'(DIV9_MUL);
		return p[DIV9_SHIFT +: CH_W];
	endfunction

endpackage

// ===== sv/rbb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module rbb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/rbb_ctrl.sv =====
// Frame geometry registers and input/output raster counters.
module rbb_ctrl #(
	parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rbb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rbb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_acc,
	output logic [$clog2(MAX_WIDTH)-1:0]      col,
	output rbb_pkg::rbb_ctl_t                 ctl
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 3);
	localparam int RST_W = (rbb_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH :
		rbb_pkg::RESET_WIDTH;
	localparam int RST_H = (rbb_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT :
		rbb_pkg::RESET_HEIGHT;

	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic          act_q;

	logic [rbb_pkg::FRAME_WIDTH_W-1:0]  wv;
	logic [rbb_pkg::FRAME_HEIGHT_W-1:0] hv;
	logic [WW-1:0] w_clamp;
	logic [HW-1:0] h_clamp;
	logic [WW-1:0] col_inc;
	logic [WW-1:0] oc_inc;
	logic [RW-1:0] or_inc;
	logic [RW-1:0] h_ext;
	logic          wrap;
	logic          out_wrap;
	logic          act_n;

	assign wv = cfg_data[rbb_pkg::FRAME_WIDTH_W-1:0];
	assign hv = cfg_data[rbb_pkg::FRAME_HEIGHT_W-1:0];

	always_comb begin
		if (32'(wv) < 32'(rbb_pkg::MIN_DIM)) begin
			w_clamp = WW'(rbb_pkg::MIN_DIM);
		end else if (32'(wv) > 32'(MAX_WIDTH)) begin
			w_clamp = WW'(MAX_WIDTH);
		end else begin
			w_clamp = WW'(wv);
		end
		if (32'(hv) < 32'(rbb_pkg::MIN_DIM)) begin
			h_clamp = HW'(rbb_pkg::MIN_DIM);
		end else if (32'(hv) > 32'(MAX_HEIGHT)) begin
			h_clamp = HW'(MAX_HEIGHT);
		end else begin
			h_clamp = HW'(hv);
		end
	end

	assign col      = in_col_q;
	assign col_inc  = WW'(in_col_q) + WW'(1);
	assign wrap     = col_inc >= w_q;
	assign act_n    = act_q | (in_row_q == RW'(1) && in_col_q == CW'(1));
	assign oc_inc   = WW'(out_col_q) + WW'(1);
	assign out_wrap = oc_inc >= w_q;
	assign or_inc   = out_row_q + RW'(1);
	assign h_ext    = RW'(h_q);

	assign ctl.emit     = act_n;
	assign ctl.interior = out_row_q != '0 && or_inc < h_ext && out_col_q != '0 && oc_inc < w_q;
	assign ctl.last     = or_inc >= h_ext && out_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= WW'(RST_W);
			h_q       <= HW'(RST_H);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			act_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbb_pkg::CFG_FRAME_WIDTH:  w_q <= w_clamp;
				rbb_pkg::CFG_FRAME_HEIGHT: h_q <= h_clamp;
				default: ;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			act_q     <= 1'b0;
		end else if (in_acc) begin
			if (act_n && ctl.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				act_q     <= 1'b0;
			end else begin
				in_col_q <= wrap ? '0 : CW'(col_inc);
				if (wrap && in_row_q <= h_ext + RW'(1)) begin
					in_row_q <= in_row_q + RW'(1);
				end
				act_q <= act_n;
				if (act_n) begin
					out_col_q <= out_wrap ? '0 : CW'(oc_inc);
					if (out_wrap) begin
						out_row_q <= or_inc;
					end
				end
			end
		end
	end

endmodule

// ===== sv/rbb_filter.sv =====
// 3x3 window, per-channel sums and the output register.
module rbb_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          valid_s1,
	input  rbb_pkg::rbb_ctl_t             ctl_s1,
	input  logic [rbb_pkg::PIX_W-1:0]     pix_s1,
	input  logic [rbb_pkg::PIX_W-1:0]     top_s1,
	input  logic [rbb_pkg::PIX_W-1:0]     mid_s1,
	output logic                          out_valid,
	output logic [rbb_pkg::CH_W-1:0]      out_red,
	output logic [rbb_pkg::CH_W-1:0]      out_green,
	output logic [rbb_pkg::CH_W-1:0]      out_blue,
	output logic                          frame_last
);

	logic [rbb_pkg::PIX_W-1:0] win_q [rbb_pkg::WIN_N];
	logic [rbb_pkg::PIX_W-1:0] win_n [rbb_pkg::WIN_N];
	logic [rbb_pkg::SUM_W-1:0] sum_n [3];

	logic                      emit_s2;
	logic                      int_s2;
	logic                      last_s2;
	logic [rbb_pkg::SUM_W-1:0] sum_s2 [3];
	logic [rbb_pkg::PIX_W-1:0] ctr_s2;

	logic                      out_valid_q;
	logic [rbb_pkg::CH_W-1:0]  red_q;
	logic [rbb_pkg::CH_W-1:0]  green_q;
	logic [rbb_pkg::CH_W-1:0]  blue_q;
	logic                      last_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_n[3*k]     = win_q[3*k+1];
			win_n[3*k + 1] = win_q[3*k+2];
		end
		win_n[2] = top_s1;
		win_n[5] = mid_s1;
		win_n[8] = pix_s1;
		for (int c = 0; c < 3; c++) begin
			sum_n[c] = '0;
			for (int i = 0; i < rbb_pkg::WIN_N; i++) begin
				sum_n[c] = sum_n[c] +
					rbb_pkg::SUM_W'(win_n[i][rbb_pkg::CH_W*c +: rbb_pkg::CH_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rbb_pkg::WIN_N; i++) begin
				win_q[i] <= '0;
			end
			emit_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (valid_s1) begin
				win_q <= win_n;
			end
			emit_s2     <= valid_s1 && ctl_s1.emit;
			out_valid_q <= emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (valid_s1) begin
				sum_s2  <= sum_n;
				ctr_s2  <= win_n[4];
				int_s2  <= ctl_s1.interior;
				last_s2 <= ctl_s1.last;
			end
			if (emit_s2) begin
				last_q <= last_s2;
				if (int_s2) begin
					red_q   <= rbb_pkg::div9(sum_s2[2]);
					green_q <= rbb_pkg::div9(sum_s2[1]);
					blue_q  <= rbb_pkg::div9(sum_s2[0]);
				end else begin
					red_q   <= ctr_s2[2*rbb_pkg::CH_W +: rbb_pkg::CH_W];
					green_q <= ctr_s2[rbb_pkg::CH_W +: rbb_pkg::CH_W];
					blue_q  <= ctr_s2[0 +: rbb_pkg::CH_W];
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = red_q;
	assign out_green  = green_q;
	assign out_blue   = blue_q;
	assign frame_last = last_q;

endmodule

// ===== sv/rgb_box_blur_3x3_unit.sv =====
// Top level: 3x3 box blur over an RGB raster stream, two line-store RAMs.
// Takes one pixel item per clock unless stalled, giving at most one result per
// item; the line-store RAMs set the rate, each read and written once per item.
// An item passes through three register stages (RAM read, window and sums,
// divide and output register); results lag the input by frame_width+1 items,
// so after a frame the host sends frame_width+1 items with drain set. Both
// geometry writes restart the frame; the user makes them only while the block
// is empty, unchecked by the block. Border pixels pass through; frame_last
// marks the frame's final result. The line stores need no clearing after reset.
module rgb_box_blur_3x3_unit #(
	parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rbb_pkg::CH_W-1:0]       in_red,
	input  logic [rbb_pkg::CH_W-1:0]       in_green,
	input  logic [rbb_pkg::CH_W-1:0]       in_blue,
	input  logic                           drain,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rbb_pkg::CH_W-1:0]       out_red,
	output logic [rbb_pkg::CH_W-1:0]       out_green,
	output logic [rbb_pkg::CH_W-1:0]       out_blue,
	output logic                           frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic                      adv;
	logic                      in_acc;
	logic                      cfg_we;
	logic [CW-1:0]             col;
	rbb_pkg::rbb_ctl_t         ctl;
	logic [rbb_pkg::PIX_W-1:0] pix;

	logic                      valid_s1;
	logic [CW-1:0]             col_s1;
	logic [rbb_pkg::PIX_W-1:0] pix_s1;
	rbb_pkg::rbb_ctl_t         ctl_s1;
	logic [rbb_pkg::PIX_W-1:0] top_s1;
	logic [rbb_pkg::PIX_W-1:0] mid_s1;
	logic                      mem_we;

	logic [rbb_pkg::PIX_W-1:0] upper_rd;
	logic [rbb_pkg::PIX_W-1:0] middle_rd;
	logic                      fwd;
	logic                      fwd_s1;
	logic [rbb_pkg::PIX_W-1:0] fwd_top_s1;
	logic [rbb_pkg::PIX_W-1:0] fwd_mid_s1;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign in_acc    = in_valid && in_ready;
	assign pix       = drain ? '0 : {in_red, in_green, in_blue};
	assign mem_we    = adv && valid_s1;
	// read and write of the same column at a frame restart
	assign fwd       = mem_we && col_s1 == col;

	rbb_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_acc    (in_acc),
		.col       (col),
		.ctl       (ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_s1     <= col;
			pix_s1     <= pix;
			ctl_s1     <= ctl;
			fwd_s1     <= fwd;
			fwd_top_s1 <= mid_s1;
			fwd_mid_s1 <= pix_s1;
		end
	end

	assign top_s1 = fwd_s1 ? fwd_top_s1 : upper_rd;
	assign mid_s1 = fwd_s1 ? fwd_mid_s1 : middle_rd;

	rbb_ram #(
		.WIDTH (rbb_pkg::PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_upper_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (col_s1),
		.wdata (mid_s1),
		.re    (in_acc),
		.raddr (col),
		.rdata (upper_rd)
	);

	rbb_ram #(
		.WIDTH (rbb_pkg::PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_middle_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (col_s1),
		.wdata (pix_s1),
		.re    (in_acc),
		.raddr (col),
		.rdata (middle_rd)
	);

	rbb_filter u_filter (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.valid_s1   (valid_s1),
		.ctl_s1     (ctl_s1),
		.pix_s1     (pix_s1),
		.top_s1     (top_s1),
		.mid_s1     (mid_s1),
		.out_valid  (out_valid),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.frame_last (frame_last)
	);

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable({out_red, out_green, out_blue, frame_last}))
		else $error("result changed while waiting");

	a_item_lands_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted item missing from read stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(col_s1) && $stable(pix_s1))
		else $error("read stage changed while stalled");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench: directed and random RGB frames through the 3x3 box blur and its predictor.
module testbench;
	import rbb_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int HOLD_CYCLES    = 400;
	localparam int unsigned NO_LIMIT   = 32'hffff_ffff;
	localparam int unsigned WIDE_ITEMS = MAX_WIDTH_DEF + 9;
	localparam int unsigned TALL_ITEMS = 40;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            last;
	} blur_px_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [CH_W-1:0]       red;
		logic [CH_W-1:0]       green;
		logic [CH_W-1:0]       blue;
		logic                  drn;
		logic                  typed;
		blur_px_t              res;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [CH_W-1:0]       in_red;
	logic [CH_W-1:0]       in_green;
	logic [CH_W-1:0]       in_blue;
	logic                  drain;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CH_W-1:0]       out_red;
	logic [CH_W-1:0]       out_green;
	logic [CH_W-1:0]       out_blue;
	logic                  frame_last;

	// blur predictor state
	logic [PIX_W-1:0]          line_upper [MAX_WIDTH_DEF];
	logic [PIX_W-1:0]          line_middle [MAX_WIDTH_DEF];
	logic [PIX_W-1:0]          blur_win [WIN_N];
	int unsigned               in_col_p;
	int unsigned               in_row_p;
	int unsigned               out_col_p;
	int unsigned               out_row_p;
	bit                        out_on;
	logic [FRAME_WIDTH_W-1:0]  width_reg;
	logic [FRAME_HEIGHT_W-1:0] height_reg;

	blur_px_t pending_px [$];
	int       errors = 0;
	int       items_sent = 0;
	int       quiet_cycles = 0;
	int       src_idle_pct = 0;
	int       snk_idle_pct = 0;
	bit       hold_req = 1'b0;
	bit       hold_taken = 1'b0;
	int       hold_left = 0;

	rgb_box_blur_3x3_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.drain      (drain),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.frame_last (frame_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < MIN_DIM)
			return MIN_DIM;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [CH_W-1:0] rand_channel(input bit sat);
		if (sat)
			return ($urandom_range(7) != 0) ? {CH_W{1'b1}} : '0;
		case ($urandom_range(7))
			0: return '0;
			1: return {CH_W{1'b1}};
			default: return CH_W'($urandom);
		endcase
	endfunction

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		dir_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	function automatic dir_row_t item_row(input logic [CH_W-1:0] r, g, b, input logic d,
			input logic typed, input logic [CH_W-1:0] er, eg, eb, input logic el);
		dir_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.red = r;
		row.green = g;
		row.blue = b;
		row.drn = d;
		row.typed = typed;
		row.res = '{er, eg, eb, el};
		return row;
	endfunction

	task automatic restart_counts();
		in_col_p = 0;
		in_row_p = 0;
		out_col_p = 0;
		out_row_p = 0;
		out_on = 1'b0;
	endtask

	task automatic apply_geometry(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		if (idx == CFG_FRAME_WIDTH)
			width_reg = data[FRAME_WIDTH_W-1:0];
		else
			height_reg = data[FRAME_HEIGHT_W-1:0];
		restart_counts();
	endtask

	task automatic predict_item(input logic [CH_W-1:0] r, g, b, input logic d,
			output bit got, output blur_px_t res);
		int unsigned      w, h, col, idx, k, sr, sg, sb;
		logic [PIX_W-1:0] px, top, mid;
		bit               interior;
		w = clamp_dim(width_reg, MAX_WIDTH_DEF);
		h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
		col = in_col_p % w;
		idx = col % MAX_WIDTH_DEF;
		px = d ? '0 : {r, g, b};
		top = line_upper[idx];
		mid = line_middle[idx];
		line_upper[idx] = mid;
		line_middle[idx] = px;
		for (k = 0; k < 3; k++) begin
			blur_win[3*k] = blur_win[3*k+1];
			blur_win[3*k+1] = blur_win[3*k+2];
		end
		blur_win[2] = top;
		blur_win[5] = mid;
		blur_win[8] = px;
		if (!out_on && in_row_p == 1 && col == 1)
			out_on = 1'b1;
		col++;
		if (col >= w) begin
			col = 0;
			if (in_row_p <= h + 1)
				in_row_p++;
		end
		in_col_p = col;
		got = out_on;
		res = '0;
		if (out_on) begin
			interior = out_row_p >= 1 && out_row_p + 1 < h && out_col_p >= 1 && out_col_p + 1 < w;
			if (interior) begin
				sr = 0;
				sg = 0;
				sb = 0;
				for (k = 0; k < WIN_N; k++) begin
					sr += blur_win[k][2*CH_W +: CH_W];
					sg += blur_win[k][CH_W +: CH_W];
					sb += blur_win[k][0 +: CH_W];
				end
				res.red = CH_W'(sr / WIN_N);
				res.green = CH_W'(sg / WIN_N);
				res.blue = CH_W'(sb / WIN_N);
			end else begin
				{res.red, res.green, res.blue} = blur_win[4];
			end
			res.last = out_row_p + 1 >= h && out_col_p + 1 >= w;
			if (res.last) begin
				restart_counts();
			end else begin
				out_col_p++;
				if (out_col_p >= w) begin
					out_col_p = 0;
					out_row_p++;
				end
			end
		end
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		errors++;
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic send_item(input logic [CH_W-1:0] r, g, b, input logic d, input bit typed,
			input blur_px_t typed_res);
		bit       got;
		blur_px_t res;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_red = r;
		in_green = g;
		in_blue = b;
		drain = d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_item(r, g, b, d, got, res);
		if (typed)
			pending_px.push_back(typed_res);
		else if (got)
			pending_px.push_back(res);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		in_valid = 1'b0;
		while (pending_px.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_geometry(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// new random geometry; small frames mostly, a few wider ones, a few below the minimum
	task automatic reshape_frame(input bit must_write);
		logic [CFG_DATA_W-1:0] wdata;
		bit                    wrote;
		wrote = 1'b0;
		if ($urandom_range(1)) begin
			case ($urandom_range(9))
				0: wdata = CFG_DATA_W'($urandom_range(2));
				1: wdata = CFG_DATA_W'($urandom_range(64, 13));
				default: wdata = CFG_DATA_W'($urandom_range(12, 3));
			endcase
			wdata[CFG_DATA_W-1:FRAME_WIDTH_W] = (CFG_DATA_W-FRAME_WIDTH_W)'($urandom);
			write_reg(CFG_FRAME_WIDTH, wdata);
			wrote = 1'b1;
		end
		if ($urandom_range(1) || (must_write && !wrote)) begin
			if ($urandom_range(7) == 0)
				write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(2)));
			else
				write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(8, 3)));
		end
	endtask

	// one frame plus its flush items; a truncated frame stops early, none goes past limit
	task automatic send_frame(input bit truncate, input int unsigned limit);
		int unsigned w, h, total, cut, k;
		bit          sat;
		logic        d;
		w = clamp_dim(width_reg, MAX_WIDTH_DEF);
		h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
		total = w * h + w + 1;
		cut = truncate ? $urandom_range(total - 1, 1) : total;
		if (cut > limit)
			cut = limit;
		sat = ($urandom_range(7) == 0);
		for (k = 0; k < cut; k++) begin
			if (k < w * h)
				d = ($urandom_range(31) == 0);
			else
				d = ($urandom_range(15) != 0);
			send_item(rand_channel(sat), rand_channel(sat), rand_channel(sat), d, 1'b0, '0);
		end
	endtask

	task automatic run_frames(input int budget);
		int start;
		bit trunc;
		start = items_sent;
		while (items_sent - start < budget) begin
			reshape_frame(1'b0);
			trunc = ($urandom_range(9) == 0);
			send_frame(trunc, NO_LIMIT);
			if (trunc)
				reshape_frame(1'b1);
		end
	endtask

	// output side: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_left = HOLD_CYCLES;
			hold_taken = 1'b1;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		blur_px_t want;
		if (out_valid && out_ready) begin
			if (pending_px.size() == 0) begin
				flag_mismatch("result with nothing expected, red", out_red, 0);
			end else begin
				want = pending_px.pop_front();
				if (out_red !== want.red)
					flag_mismatch("out_red", out_red, want.red);
				if (out_green !== want.green)
					flag_mismatch("out_green", out_green, want.green);
				if (out_blue !== want.blue)
					flag_mismatch("out_blue", out_blue, want.blue);
				if (frame_last !== want.last)
					flag_mismatch("frame_last", frame_last, want.last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : main
		dir_row_t dir_tab [$];
		int       i;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_red = '0;
		in_green = '0;
		in_blue = '0;
		drain = 1'b0;
		width_reg = RESET_WIDTH;
		height_reg = RESET_HEIGHT;
		for (i = 0; i < MAX_WIDTH_DEF; i++) begin
			line_upper[i] = '0;
			line_middle[i] = '0;
		end
		for (i = 0; i < WIN_N; i++)
			blur_win[i] = '0;
		restart_counts();

		// 3x3 frame: both sizes written below the minimum, drain inside the frame,
		// a pixel in a flush slot; results lag four items
		dir_tab.push_back(cfg_row(CFG_FRAME_WIDTH, 13'h1802));
		dir_tab.push_back(cfg_row(CFG_FRAME_HEIGHT, 13'h0000));
		dir_tab.push_back(item_row(255, 255, 255, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(item_row(0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(item_row(255, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(item_row(0, 255, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(item_row(0, 0, 255, 0, 1, 255, 255, 255, 0));
		dir_tab.push_back(item_row(170, 85, 1, 0, 1, 0, 0, 0, 0));
		dir_tab.push_back(item_row(9, 9, 9, 1, 1, 255, 0, 0, 0));
		dir_tab.push_back(item_row(255, 255, 255, 0, 1, 0, 255, 0, 0));
		dir_tab.push_back(item_row(1, 2, 3, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(item_row(200, 100, 50, 1, 1, 170, 85, 1, 0));
		dir_tab.push_back(item_row(77, 77, 77, 0, 1, 0, 0, 0, 0));
		dir_tab.push_back(item_row(0, 0, 0, 1, 1, 255, 255, 255, 0));
		dir_tab.push_back(item_row(0, 0, 0, 1, 1, 1, 2, 3, 1));

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		src_idle_pct = 34;
		snk_idle_pct = 56;
		foreach (dir_tab[j]) begin
			if (dir_tab[j].kind == ROW_CFG)
				write_reg(dir_tab[j].idx, dir_tab[j].data);
			else
				send_item(dir_tab[j].red, dir_tab[j].green, dir_tab[j].blue, dir_tab[j].drn,
					dir_tab[j].typed, dir_tab[j].res);
		end
		run_frames(130);

		src_idle_pct = 56;
		snk_idle_pct = 34;
		run_frames(140);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_req = 1'b1;
		run_frames(130);

		// widest and tallest frames, both written above the maximum, cut short after
		// the first results
		write_reg(CFG_FRAME_WIDTH, {CFG_DATA_W{1'b1}});
		write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(MIN_DIM));
		send_frame(1'b0, WIDE_ITEMS);
		write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(MIN_DIM));
		write_reg(CFG_FRAME_HEIGHT, {CFG_DATA_W{1'b1}});
		send_frame(1'b0, TALL_ITEMS);

		in_valid = 1'b0;
		while (pending_px.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
